FILE: hdl/frac_red_pkg.sv
// Shared types and constants for the fraction reducer.
// Holds the transaction payload structs and the divider request/response structs.
// No dependencies.
`timescale 1ns / 1ps

package frac_red_pkg;

    // Width of the signed input operands.
    localparam int DATA_WIDTH = 32;
    // Counter width able to hold DATA_WIDTH itself.
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH + 1);

    // Status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BOTH_ZERO = 1'b1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] numer_in;
        logic signed [DATA_WIDTH-1:0] denom_in;
    } frac_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] numer_out;
        logic        [DATA_WIDTH-2:0] denom_out;
        logic        [DATA_WIDTH-2:0] divisor_out;
        logic                         status;
    } frac_out_t;

    // Request to the shared serial divider.
    typedef struct packed {
        logic                  start;
        logic [DATA_WIDTH-1:0] dividend;
        logic [DATA_WIDTH-1:0] divisor;
    } div_req_t;

    // Response from the shared serial divider.
    typedef struct packed {
        logic                  done;
        logic [DATA_WIDTH-1:0] quotient;
        logic [DATA_WIDTH-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: hdl/frac_red_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on frac_red_pkg for the data width and request/response structs.
`timescale 1ns / 1ps

module frac_red_divider (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  frac_red_pkg::div_req_t req,
    output frac_red_pkg::div_rsp_t rsp
);
    import frac_red_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_WIDTH-1:0]  cnt_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] rem_reg;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] quo_next;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, den_reg};
        if (!diff[DATA_WIDTH]) begin
            rem_next = diff[DATA_WIDTH-1:0];
            quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
        end else begin
            rem_next = shifted[DATA_WIDTH-1:0];
            quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
        end
    end

    // Load operands on start, then advance one bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_WIDTH'(DATA_WIDTH);
                den_reg  <= req.divisor;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - CNT_WIDTH'(1);
                if (cnt_reg == CNT_WIDTH'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: hdl/fraction_reducer_core.sv
// Fraction reducer: gcd by Euclid's remainder method, then reduction of both terms.
// Depends on frac_red_pkg and frac_red_divider.
//
// Usage:
//   s_ channel carries one signed numerator/denominator pair per transaction;
//   m_ channel returns one result per input: reduced numerator (carries the
//   sign), reduced denominator (never negative), the gcd and a status bit
//   that is set when both inputs are zero (all other fields then zero).
//   One item is in flight at a time: s_ready is high only while idle, and
//   drops from acceptance until the result transaction completes.
//   Every division runs on the shared restoring divider. With k Euclid steps,
//   a result takes k + 2 divisions: k for the remainders, then one for each
//   magnitude by the gcd; for 32-bit inputs k is at most 46. A zero
//   denominator skips the loop, a zero numerator takes one step, and two zero
//   inputs go from ST_GCD straight to the output register, with no division.
//   The result stays in the output register, held stable, while m_ready is
//   low; the next input is taken once it has been delivered.
//   Reset (aresetn low, synchronous) returns to idle and drops m_valid.
`timescale 1ns / 1ps

module fraction_reducer_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  frac_red_pkg::frac_in_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output frac_red_pkg::frac_out_t m_data
);
    import frac_red_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_GCD_WAIT,
        ST_DIVN,
        ST_DIVN_WAIT,
        ST_DIVD,
        ST_DIVD_WAIT,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] nmag_reg;
    logic [DATA_WIDTH-1:0] dmag_reg;
    logic [DATA_WIDTH-1:0] qn_reg;
    logic                  neg_reg;
    logic                  m_valid_reg;
    frac_out_t             m_data_reg;

    logic                  s_accept;
    logic                  numer_neg;
    logic                  denom_neg;
    logic [DATA_WIDTH-1:0] numer_mag;
    logic [DATA_WIDTH-1:0] denom_mag;
    logic [DATA_WIDTH-1:0] qn_signed;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // Split inputs into sign and magnitude; the most negative value maps to 2^(W-1)
    always_comb begin
        numer_neg = s_data.numer_in[DATA_WIDTH-1];
        denom_neg = s_data.denom_in[DATA_WIDTH-1];
        numer_mag = numer_neg ? (~s_data.numer_in + DATA_WIDTH'(1)) : s_data.numer_in;
        denom_mag = denom_neg ? (~s_data.denom_in + DATA_WIDTH'(1)) : s_data.denom_in;
    end

    // Apply the fraction's sign to the reduced numerator
    assign qn_signed = neg_reg ? (~qn_reg + DATA_WIDTH'(1)) : qn_reg;

    // Route operands to the shared divider according to the current step
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = a_reg;
        div_req.divisor  = b_reg;
        case (state_reg)
            ST_GCD: begin
                div_req.start = (b_reg != '0);
            end
            ST_DIVN: begin
                div_req.start    = 1'b1;
                div_req.dividend = nmag_reg;
                div_req.divisor  = a_reg;
            end
            ST_DIVD: begin
                div_req.start    = 1'b1;
                div_req.dividend = dmag_reg;
                div_req.divisor  = a_reg;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    frac_red_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer: Euclid loop, then divide both magnitudes by the gcd
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        a_reg     <= numer_mag;
                        b_reg     <= denom_mag;
                        nmag_reg  <= numer_mag;
                        dmag_reg  <= denom_mag;
                        neg_reg   <= numer_neg != denom_neg;
                        state_reg <= ST_GCD;
                    end
                end
                ST_GCD: begin
                    if (b_reg != '0) begin
                        state_reg <= ST_GCD_WAIT;
                    end else if (a_reg == '0) begin
                        // both inputs zero: no reduction
                        m_data_reg.numer_out   <= '0;
                        m_data_reg.denom_out   <= '0;
                        m_data_reg.divisor_out <= '0;
                        m_data_reg.status      <= STATUS_BOTH_ZERO;
                        m_valid_reg            <= 1'b1;
                        state_reg              <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIVN;
                    end
                end
                ST_GCD_WAIT: begin
                    if (div_rsp.done) begin
                        a_reg     <= b_reg;
                        b_reg     <= div_rsp.remainder;
                        state_reg <= ST_GCD;
                    end
                end
                ST_DIVN: begin
                    state_reg <= ST_DIVN_WAIT;
                end
                ST_DIVN_WAIT: begin
                    if (div_rsp.done) begin
                        qn_reg    <= div_rsp.quotient;
                        state_reg <= ST_DIVD;
                    end
                end
                ST_DIVD: begin
                    state_reg <= ST_DIVD_WAIT;
                end
                ST_DIVD_WAIT: begin
                    if (div_rsp.done) begin
                        m_data_reg.numer_out   <= qn_signed;
                        m_data_reg.denom_out   <= div_rsp.quotient[DATA_WIDTH-2:0];
                        m_data_reg.divisor_out <= a_reg[DATA_WIDTH-2:0];
                        m_data_reg.status      <= STATUS_OK;
                        m_valid_reg            <= 1'b1;
                        state_reg              <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    m_valid_reg <= 1'b0;
                    state_reg   <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Input is never taken while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // An accepted transaction closes the input until its result is delivered
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("input ready right after acceptance");

    // The both-zero status carries all-zero result fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status) |->
            (m_data.numer_out == '0 && m_data.denom_out == '0 &&
             m_data.divisor_out == '0))
        else $error("both-zero status with nonzero fields");

    // Divider completions arrive only while the sequencer waits for one
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |->
            (state_reg == ST_GCD_WAIT || state_reg == ST_DIVN_WAIT ||
             state_reg == ST_DIVD_WAIT))
        else $error("divider done outside a wait state");

    // The divider is never started with a zero divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> (div_req.divisor != '0))
        else $error("division by zero requested");

endmodule
